// ----- hw/rtl/hhio_pkg.sv -----
package hhio_pkg;

  localparam logic [6:0] R_JOYP  = 7'h00;
  localparam logic [6:0] R_DIV   = 7'h04;
  localparam logic [6:0] R_NR10  = 7'h10;
  localparam logic [6:0] R_NR52  = 7'h26;
  localparam logic [6:0] R_LCDC  = 7'h40;
  localparam logic [6:0] R_DMA   = 7'h46;
  localparam logic [6:0] R_KEY1  = 7'h4D;
  localparam logic [6:0] R_VBK   = 7'h4F;
  localparam logic [6:0] R_HDMA1 = 7'h51;
  localparam logic [6:0] R_HDMA2 = 7'h52;
  localparam logic [6:0] R_HDMA3 = 7'h53;
  localparam logic [6:0] R_HDMA4 = 7'h54;
  localparam logic [6:0] R_HDMA5 = 7'h55;
  localparam logic [6:0] R_RP    = 7'h56;
  localparam logic [6:0] R_BGPI  = 7'h68;
  localparam logic [6:0] R_BGPD  = 7'h69;
  localparam logic [6:0] R_OBPI  = 7'h6A;
  localparam logic [6:0] R_OBPD  = 7'h6B;
  localparam logic [6:0] R_SVBK  = 7'h70;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] HEV_NONE   = 2'd0;
  localparam logic [1:0] HEV_GDMA   = 2'd1;
  localparam logic [1:0] HEV_HBLANK = 2'd2;
  localparam logic [1:0] HEV_CANCEL = 2'd3;

  localparam logic [1:0] LCD_NONE = 2'd0;
  localparam logic [1:0] LCD_ON   = 2'd1;
  localparam logic [1:0] LCD_OFF  = 2'd2;

  localparam logic [0:0] CFG_COLOUR_MODE = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [6:0] offset;
    logic [7:0] write_data;
    logic       override;
    logic [3:0] buttons;
    logic [3:0] dpad;
    logic [3:0] channel_on;
    logic       sound_off;
    logic       hdma_busy;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        dma_start;
    logic [15:0] dma_source;
    logic [1:0]  hdma_event;
    logic [15:0] hdma_source;
    logic [15:0] hdma_dest;
    logic [11:0] hdma_length;
    logic [2:0]  work_bank;
    logic        video_bank;
    logic        div_reset;
    logic [1:0]  lcd_control;
    logic        sound_write;
  } rsp_t;

  function automatic logic [7:0] rd_mask(input logic [6:0] a);
    logic [7:0] m;
    m = 8'h00;
    unique case (a)
      7'h00: m = 8'h3F; 7'h01: m = 8'hFF; 7'h02: m = 8'h83; 7'h04: m = 8'hFF;
      7'h05: m = 8'hFF; 7'h06: m = 8'hFF; 7'h07: m = 8'h07; 7'h0F: m = 8'h1F;
      7'h10: m = 8'h7F; 7'h11: m = 8'hC0; 7'h12: m = 8'hFF; 7'h14: m = 8'h40;
      7'h16: m = 8'hC0; 7'h17: m = 8'hFF; 7'h19: m = 8'h40; 7'h1A: m = 8'h80;
      7'h1C: m = 8'h60; 7'h1E: m = 8'h40; 7'h21: m = 8'hFF; 7'h22: m = 8'hFF;
      7'h23: m = 8'h40; 7'h24: m = 8'hFF; 7'h25: m = 8'hFF; 7'h26: m = 8'h8F;
      7'h41: m = 8'h7F; 7'h4D: m = 8'h81; 7'h4F: m = 8'h01;
      7'h51, 7'h52, 7'h53, 7'h54, 7'h55: m = 8'hFF;
      7'h56: m = 8'hC3;
      7'h68, 7'h69, 7'h6A, 7'h6B: m = 8'hFF;
      7'h70: m = 8'h07;
      default: begin
        if (a >= 7'h30 && a <= 7'h4B && a != 7'h41) m = 8'hFF;
      end
    endcase
    return m;
  endfunction

  function automatic logic [7:0] wr_mask(input logic [6:0] a);
    logic [7:0] m;
    m = 8'h00;
    unique case (a)
      7'h00: m = 8'h30; 7'h01: m = 8'hFF; 7'h02: m = 8'h83; 7'h04: m = 8'hFF;
      7'h05: m = 8'hFF; 7'h06: m = 8'hFF; 7'h07: m = 8'h07; 7'h0F: m = 8'h1F;
      7'h10: m = 8'h7F; 7'h11: m = 8'hFF; 7'h12: m = 8'hFF; 7'h13: m = 8'hFF;
      7'h14: m = 8'hC7; 7'h16: m = 8'hFF; 7'h17: m = 8'hFF; 7'h18: m = 8'hFF;
      7'h19: m = 8'hC7; 7'h1A: m = 8'h80; 7'h1B: m = 8'hFF; 7'h1C: m = 8'h60;
      7'h1D: m = 8'hFF; 7'h1E: m = 8'hC7; 7'h20: m = 8'h3F; 7'h21: m = 8'hFF;
      7'h22: m = 8'hFF; 7'h23: m = 8'hC0; 7'h24: m = 8'hFF; 7'h25: m = 8'hFF;
      7'h26: m = 8'h80; 7'h41: m = 8'h78; 7'h44: m = 8'h00; 7'h4D: m = 8'h01;
      7'h4F: m = 8'h01; 7'h51: m = 8'hFF; 7'h52: m = 8'hF0; 7'h53: m = 8'h1F;
      7'h54: m = 8'hF0; 7'h55: m = 8'hFF; 7'h56: m = 8'hC2;
      7'h68, 7'h69, 7'h6A, 7'h6B: m = 8'hFF;
      7'h70: m = 8'h07;
      default: begin
        if (a >= 7'h30 && a <= 7'h4B) m = 8'hFF;
      end
    endcase
    return m;
  endfunction

  function automatic logic colour_only(input logic [6:0] a);
    return a == R_KEY1 || a == R_VBK || (a >= R_HDMA1 && a <= R_RP) ||
           (a >= R_BGPI && a <= R_OBPD) || a == R_SVBK;
  endfunction

endpackage

// ----- hw/rtl/hhio_ram.sv -----
module hhio_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/handheld_io_register_file_unit.sv -----
// Register file of a colour handheld's I/O page (0xFF00-0xFF7F) plus the
// background and object palette stores.
// Slave stream: one bus request per item (kind, offset, write data, raw
// override, live keys, sound flags, block-transfer busy). Master stream:
// one result per request (read byte plus event and bank outputs).
// Every request runs three phases: read the memories (registered RAM
// output), update and write back, hand the result to the output register.
// The next request enters once the previous result is in the output
// register: the read-modify-write through the register RAM is done before
// a new request is taken. A waiting result does not stop the next request
// from being read and computed; it holds only the write-back.
// Registers that are side outputs (bank selects, block-transfer addresses,
// palette indexes) are shadowed in flip-flops so one RAM read suffices.
// Reset: a clearing pass zeroes the register RAM and the shared palette
// RAM; no request is taken meanwhile, configuration is.
// Colour mode resets to 1. A stalled master holds the result and its payload.
module handheld_io_register_file_unit #(
  parameter int REG_COUNT     = 128,
  parameter int PALETTE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind, offset, write_data, override, buttons, dpad, channel_on,
  // sound_off, hdma_busy, zero pad (low to high)
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data, dma_start, dma_source, hdma_event, hdma_source, hdma_dest,
  // hdma_length, work_bank, video_bank, div_reset, lcd_control, sound_write,
  // zero pad (low to high)
  output logic [79:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int RAW = $clog2(REG_COUNT);
  localparam int PAW = $clog2(PALETTE_BYTES);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t           state;
  logic [RAW:0]     clr_cnt;
  logic             colour_mode;
  hhio_pkg::req_t   req;
  hhio_pkg::rsp_t   rsp, rsp_next;
  logic [7:0]       svbk, vbk, hdma1, hdma2, hdma3, hdma4, bgpi, obpi;

  logic             reg_we, pal_we;
  logic [RAW-1:0]   reg_waddr;
  logic [7:0]       reg_wdata, pal_wdata, reg_rdata, pal_rdata;
  logic [PAW:0]     pal_waddr, pal_raddr;

  assign pready = 1'b1;
  assign prdata = {31'd0, colour_mode};

  always_ff @(posedge clk) begin
    if (rst) colour_mode <= 1'b1;
    else if (psel && penable && pwrite && paddr[2] == hhio_pkg::CFG_COLOUR_MODE &&
             paddr[1:0] == 2'b00)
      colour_mode <= pwdata[0];
  end

  assign s_tready = (state == ST_IDLE);

  // background palette in the lower half, object palette in the upper half
  assign pal_raddr = (req.offset == hhio_pkg::R_OBPD) ? {1'b1, obpi[PAW-1:0]}
                                                      : {1'b0, bgpi[PAW-1:0]};

  hhio_ram #(.DEPTH(REG_COUNT), .AW(RAW)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(req.offset[RAW-1:0]), .rdata(reg_rdata));
  hhio_ram #(.DEPTH(2 * PALETTE_BYTES), .AW(PAW + 1)) u_pal (
    .clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata));

  // update logic, valid in ST_WRITE
  logic       blocked, do_store, pal_inc;
  logic [7:0] store_val, m, merged, rv, idx, idx_inc;
  logic [3:0] pressed;
  logic       wr;
  logic [6:0] a;

  always_comb begin
    wr = req.kind == hhio_pkg::KIND_WRITE;
    a = req.offset;
    blocked = !colour_mode && hhio_pkg::colour_only(a);
    m = hhio_pkg::wr_mask(a);
    merged = (reg_rdata & ~m) | (req.write_data & m);
    do_store = 1'b0;
    store_val = merged;
    pal_inc = 1'b0;
    idx = (a == hhio_pkg::R_BGPD) ? bgpi : obpi;
    idx_inc = idx + 8'd1;
    if (idx_inc[6:0] == 7'h40) idx_inc = 8'h80;
    rsp_next = '0;
    pressed = 4'd0;
    rv = reg_rdata;

    if (!wr) begin
      if (blocked) rsp_next.read_data = 8'hFF;
      else if (req.override) rsp_next.read_data = reg_rdata;
      else if (a == hhio_pkg::R_JOYP) begin
        if (!reg_rdata[5]) pressed = pressed | req.buttons;
        if (!reg_rdata[4]) pressed = pressed | req.dpad;
        rsp_next.read_data = {2'b11, reg_rdata[5:4], ~pressed};
      end else begin
        if (a == hhio_pkg::R_NR52) rv = {reg_rdata[7:4], req.channel_on};
        else if (a == hhio_pkg::R_BGPD || a == hhio_pkg::R_OBPD) rv = pal_rdata;
        rsp_next.read_data = rv | ~hhio_pkg::rd_mask(a);
      end
    end else if (blocked) begin
      do_store = 1'b0;
    end else if (req.override) begin
      do_store = 1'b1;
      store_val = req.write_data;
    end else if (a >= hhio_pkg::R_NR10 && a <= hhio_pkg::R_NR52) begin
      if (a == hhio_pkg::R_NR52 || !req.sound_off) begin
        do_store = 1'b1;
        rsp_next.sound_write = 1'b1;
      end
    end else if (a == hhio_pkg::R_DIV) begin
      do_store = 1'b1;
      store_val = 8'h00;
      rsp_next.div_reset = 1'b1;
    end else if (a == hhio_pkg::R_LCDC) begin
      do_store = 1'b1;
      rsp_next.lcd_control = req.write_data[7] ? hhio_pkg::LCD_ON : hhio_pkg::LCD_OFF;
    end else if (a == hhio_pkg::R_DMA) begin
      do_store = 1'b1;
      rsp_next.dma_start = 1'b1;
      rsp_next.dma_source = {req.write_data, 8'h00};
    end else if (a == hhio_pkg::R_HDMA1) begin
      do_store = req.write_data < 8'h80 ||
                 (req.write_data >= 8'hA0 && req.write_data < 8'hE0);
      store_val = req.write_data;
    end else if (a == hhio_pkg::R_HDMA5) begin
      do_store = 1'b1;
      if (!req.write_data[7] && req.hdma_busy) begin
        store_val = reg_rdata | 8'h80;
        rsp_next.hdma_event = hhio_pkg::HEV_CANCEL;
      end else begin
        store_val = req.write_data;
        rsp_next.hdma_source = {hdma1, hdma2};
        rsp_next.hdma_dest = {hdma3 | 8'h80, hdma4};
        rsp_next.hdma_length = {1'b0, req.write_data[6:0], 4'h0} + 12'h010;
        rsp_next.hdma_event = req.write_data[7] ? hhio_pkg::HEV_HBLANK
                                                : hhio_pkg::HEV_GDMA;
      end
    end else if (a == hhio_pkg::R_RP) begin
      do_store = 1'b0;
    end else if (a == hhio_pkg::R_BGPD || a == hhio_pkg::R_OBPD) begin
      pal_inc = idx[7];
    end else if (a == hhio_pkg::R_SVBK) begin
      do_store = 1'b1;
      store_val = (req.write_data[2:0] == 3'd0) ? 8'h01 : {5'd0, req.write_data[2:0]};
    end else begin
      do_store = 1'b1;
    end

    // bank outputs reflect state after this request
    rsp_next.work_bank = (do_store && a == hhio_pkg::R_SVBK) ? store_val[2:0] : svbk[2:0];
    if (rsp_next.work_bank == 3'd0) rsp_next.work_bank = 3'd1;
    rsp_next.video_bank = (do_store && a == hhio_pkg::R_VBK) ? store_val[0] : vbk[0];
  end

  logic busy_out;
  assign busy_out = m_tvalid && !m_tready;
  logic commit;
  assign commit = (state == ST_WRITE) && !busy_out;

  always_comb begin
    reg_we = 1'b0;
    reg_waddr = a[RAW-1:0];
    reg_wdata = store_val;
    pal_we = 1'b0;
    pal_waddr = {a == hhio_pkg::R_OBPD, idx[PAW-1:0]};
    pal_wdata = req.write_data;
    if (state == ST_CLEAR) begin
      reg_we = 1'b1;
      reg_waddr = clr_cnt[RAW-1:0];
      reg_wdata = 8'h00;
      pal_we = 1'b1;
      pal_waddr = clr_cnt[PAW:0];
      pal_wdata = 8'h00;
    end else if (commit && wr && !blocked && !req.override &&
                 (a == hhio_pkg::R_BGPD || a == hhio_pkg::R_OBPD)) begin
      pal_we = 1'b1;
      reg_we = pal_inc;
      reg_waddr = (a == hhio_pkg::R_BGPD) ? hhio_pkg::R_BGPI[RAW-1:0]
                                          : hhio_pkg::R_OBPI[RAW-1:0];
      reg_wdata = idx_inc;
    end else if (commit && wr) begin
      reg_we = do_store;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      m_tvalid <= 1'b0;
      svbk <= 8'h00; vbk <= 8'h00; hdma1 <= 8'h00; hdma2 <= 8'h00;
      hdma3 <= 8'h00; hdma4 <= 8'h00; bgpi <= 8'h00; obpi <= 8'h00;
    end else begin
      if (commit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (reg_we && state != ST_CLEAR) begin
        unique case (reg_waddr)
          hhio_pkg::R_SVBK[RAW-1:0]:  svbk <= reg_wdata;
          hhio_pkg::R_VBK[RAW-1:0]:   vbk <= reg_wdata;
          hhio_pkg::R_HDMA1[RAW-1:0]: hdma1 <= reg_wdata;
          hhio_pkg::R_HDMA2[RAW-1:0]: hdma2 <= reg_wdata;
          hhio_pkg::R_HDMA3[RAW-1:0]: hdma3 <= reg_wdata;
          hhio_pkg::R_HDMA4[RAW-1:0]: hdma4 <= reg_wdata;
          hhio_pkg::R_BGPI[RAW-1:0]:  bgpi <= reg_wdata;
          hhio_pkg::R_OBPI[RAW-1:0]:  obpi <= reg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (RAW+1)'(REG_COUNT - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (s_tvalid) state <= ST_READ;
        ST_READ: state <= ST_WRITE;
        ST_WRITE: begin
          if (!busy_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) req <= {s_tdata[0], s_tdata[7:1], s_tdata[15:8],
      s_tdata[16], s_tdata[20:17], s_tdata[24:21], s_tdata[28:25], s_tdata[29],
      s_tdata[30]};
    if (commit) rsp <= rsp_next;
  end

  assign m_tdata = {1'b0, rsp.sound_write, rsp.lcd_control, rsp.div_reset, rsp.video_bank,
                    rsp.work_bank, rsp.hdma_length, rsp.hdma_dest, rsp.hdma_source,
                    rsp.hdma_event, rsp.dma_source, rsp.dma_start, rsp.read_data};
endmodule
